FILE: hdl/olir_pkg.sv
`default_nettype none

package olir_pkg;

  localparam int OLIR_DEPTH = 16;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE     = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                    occ;
    logic signed [VAL_W-1:0] entry;
  } link_t;

  typedef struct packed {
    logic vld;
    logic shift;
  } tok_t;

  typedef struct packed {
    logic                    push_front;
    logic                    push_back;
    logic signed [VAL_W-1:0] data;
  } bcast_t;

endpackage

`default_nettype wire

FILE: hdl/olir_in_if.sv
`default_nettype none

interface olir_in_if;
  import olir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic        [OP_W-1:0]  opcode;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);

endinterface

`default_nettype wire

FILE: hdl/olir_out_if.sv
`default_nettype none

interface olir_out_if;
  import olir_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink (input valid, input status, input entry_count, output ready);

endinterface

`default_nettype wire

FILE: hdl/ordered_list_insert_remove.sv
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values held in a row of cells.
// Each request carries an opcode and a value: insert at the front, insert at
// the back, or remove the first entry equal to the value. Each request returns
// one result with a status (done, not found, full) and the entry count after
// the operation. Inserts and requests that change nothing are answered from
// the idle state; the next request is taken in the following cycle while the
// output register is free or being read. A remove sends a token down the row,
// one cell per cycle, that finds the entry and closes the gap behind it, and no
// new request is taken meanwhile; a remove from an empty list sends no token.
module ordered_list_insert_remove #(
  parameter int DEPTH = olir_pkg::OLIR_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  olir_in_if.sink    in_req,
  olir_out_if.source out_res
);
  import olir_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]              state_r;
  logic [1:0]              state_nxt;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic signed [VAL_W-1:0] key_r;
  logic                    found_r;
  logic                    found_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [ST_W-1:0]         status_r;
  logic [ST_W-1:0]         status_nxt;
  logic [CNT_W-1:0]        out_cnt_r;
  logic [CNT_W-1:0]        out_cnt_nxt;
  logic [CW+CNT_W-1:0]     cnt_ext;

  logic   acc;
  logic   out_free;
  logic   full;
  logic   start_scan;
  logic   tok_exit;
  bcast_t bc;

  link_t cell_q   [DEPTH];
  link_t left_l   [DEPTH];
  link_t right_l  [DEPTH];
  tok_t  tok_l    [DEPTH+1];

  assign out_free     = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == S_IDLE) && out_free;
  assign acc          = in_req.valid && in_req.ready;
  assign full         = (count_r == CW'(DEPTH));
  assign start_scan   = acc && (in_req.opcode == OP_REMOVE) && (count_r != '0);
  assign tok_exit     = tok_l[DEPTH].vld;

  assign bc.push_front = acc && (in_req.opcode == OP_PUSH_FRONT) && !full;
  assign bc.push_back  = acc && (in_req.opcode == OP_PUSH_BACK) && !full;
  assign bc.data       = (state_r == S_IDLE) ? in_req.value : key_r;

  assign tok_l[0].vld   = start_scan;
  assign tok_l[0].shift = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_l[i].occ   = 1'b1;
      assign left_l[i].entry = bc.data;
    end else begin : g_mid
      assign left_l[i] = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_l[i] = '0;
    end else begin : g_inner
      assign right_l[i] = cell_q[i+1];
    end

    olir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bc       (bc),
      .left_in  (left_l[i]),
      .right_in (right_l[i]),
      .tok_in   (tok_l[i]),
      .link_out (cell_q[i]),
      .tok_out  (tok_l[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    status_nxt    = status_r;
    out_cnt_nxt   = out_cnt_r;

    if (bc.push_front || bc.push_back) begin
      count_nxt = count_r + CW'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc && !start_scan) begin
          out_valid_nxt = 1'b1;
          unique case (in_req.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: status_nxt = full ? ST_FULL : ST_DONE;
            OP_REMOVE:                   status_nxt = ST_NOT_FOUND;
            default:                     status_nxt = ST_DONE;
          endcase
        end else if (start_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_exit) begin
          state_nxt = S_HOLD;
          found_nxt = tok_l[DEPTH].shift;
          if (tok_l[DEPTH].shift) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = found_r ? ST_DONE : ST_NOT_FOUND;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    cnt_ext = {{CNT_W{1'b0}}, count_nxt};
    if ((state_r == S_IDLE && acc && !start_scan) || (state_r == S_HOLD && out_free)) begin
      out_cnt_nxt = cnt_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    found_r   <= found_nxt;
    status_r  <= status_nxt;
    out_cnt_r <= out_cnt_nxt;
    if (acc) begin
      key_r <= in_req.value;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = status_r;
  assign out_res.entry_count = out_cnt_r;

`ifndef SYNTH
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds list depth");

  a_token_exit_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tok_exit |-> (state_r == S_SCAN))
    else $error("search token left the cell row outside a remove");

  a_count_holds_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !tok_exit) |=> (count_r == $past(count_r)))
    else $error("entry count changed while a remove was in flight");

  a_scan_leaves_to_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && tok_exit) |=> (state_r == S_HOLD && !in_req.ready))
    else $error("remove result not held after token exit");
`endif

endmodule

`default_nettype wire

FILE: hdl/olir_cell.sv
`default_nettype none

module olir_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire olir_pkg::bcast_t bc,
  input  wire olir_pkg::link_t  left_in,
  input  wire olir_pkg::link_t  right_in,
  input  wire olir_pkg::tok_t   tok_in,
  output olir_pkg::link_t       link_out,
  output olir_pkg::tok_t        tok_out
);
  import olir_pkg::*;

  logic                    occ_r;
  logic                    occ_nxt;
  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  tok_t                    tok_r;
  logic                    match;

  // A search token that finds the key here starts a shift that travels on to the right.
  assign match = occ_r && (entry_r == bc.data);

  always_comb begin
    occ_nxt   = occ_r;
    entry_nxt = entry_r;
    priority if (bc.push_front) begin
      occ_nxt   = left_in.occ;
      entry_nxt = left_in.entry;
    end else if (bc.push_back && !occ_r && left_in.occ) begin
      occ_nxt   = 1'b1;
      entry_nxt = bc.data;
    end else if (tok_r.vld && (tok_r.shift || match)) begin
      occ_nxt   = right_in.occ;
      entry_nxt = right_in.entry;
    end else begin
      occ_nxt   = occ_r;
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      tok_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      tok_r <= tok_in;
    end
    entry_r <= entry_nxt;
  end

  assign link_out.occ   = occ_r;
  assign link_out.entry = entry_r;
  assign tok_out.vld    = tok_r.vld;
  assign tok_out.shift  = tok_r.shift || match;

endmodule

`default_nettype wire
